// ===== sv/drqr_pkg.sv =====
package drqr_pkg;

    localparam int CODE_W    = 14;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 3;
    localparam int HOLD_W    = 16;
    localparam int WAIT_W    = 16;
    localparam int RETRY_W   = 6;
    localparam int PERIOD_W  = 24;
    localparam int SEED_W    = 16;
    localparam int LFSR_W    = 16;
    localparam int IN_W      = 16;
    localparam int MAX_DRAWS = 4;
    localparam int CODE_MOD  = 9999;

    localparam logic [LFSR_W-1:0]   LFSR_TAPS      = 16'hB400;
    localparam logic [HOLD_W-1:0]   HOLD_RESET     = 16'd5000;
    localparam logic [WAIT_W-1:0]   TIMEOUT_RESET  = 16'd30000;
    localparam logic [RETRY_W-1:0]  RETRIES_RESET  = 6'd20;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET   = 24'd900000;
    localparam logic [SEED_W-1:0]   SEED_RESET     = 16'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HOLD,
        CFG_RESEND_WAIT,
        CFG_RETRY_LIMIT,
        CFG_REPORT_PERIOD,
        CFG_CODE_SEED
    } cfg_idx_t;

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_ACK  = 1'b1
    } op_t;

    typedef logic [CODE_W-1:0] code_t;

    typedef struct packed {
        logic  by_change;
        logic  level;
        logic  gate;
        code_t code;
    } msg_t;

endpackage

// ===== sv/drqr_code_gen.sv =====
module drqr_code_gen
    import drqr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  logic [SEED_W-1:0] seed,
    input  logic              advance,
    input  logic [2:0]        steps,
    output code_t             codes [MAX_DRAWS]
);

    logic [LFSR_W-1:0] lfsr_reg;
    logic [LFSR_W-1:0] lfsr_next;
    logic [LFSR_W-1:0] st [MAX_DRAWS+1];

    function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] s);
        lfsr_step = s[0] ? ((s >> 1) ^ LFSR_TAPS) : (s >> 1);
    endfunction

    // remainder by compare against the few multiples that fit in 16 bits
    function automatic code_t reduce(input logic [LFSR_W-1:0] x);
        logic [LFSR_W-1:0] r;
        logic              done;
        r    = x;
        done = 1'b0;
        for (int k = 6; k >= 1; k--)
        begin
            if (!done && (x >= LFSR_W'(k * CODE_MOD)))
            begin
                r    = x - LFSR_W'(k * CODE_MOD);
                done = 1'b1;
            end
        end
        reduce = r[CODE_W-1:0] + 1'b1;
    endfunction

    always_comb
    begin
        st[0] = lfsr_reg;
        for (int k = 0; k < MAX_DRAWS; k++)
        begin
            st[k+1]  = lfsr_step(st[k]);
            codes[k] = reduce(st[k+1]);
        end
    end

    always_comb
    begin
        if (load)
        begin
            lfsr_next = (seed == '0) ? LFSR_W'(1) : seed;
        end
        else if (advance)
        begin
            lfsr_next = st[steps];
        end
        else
        begin
            lfsr_next = lfsr_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lfsr_reg <= SEED_RESET;
        end
        else
        begin
            lfsr_reg <= lfsr_next;
        end
    end

endmodule

// ===== sv/drqr_debounce.sv =====
module drqr_debounce
    import drqr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              level,
    input  logic [HOLD_W-1:0] hold,
    output logic              enq
);

    logic              settled_reg;
    logic              settled_next;
    logic              pend_reg;
    logic              pend_next;
    logic [HOLD_W-1:0] cnt_reg;
    logic [HOLD_W-1:0] cnt_next;
    logic              eq;
    logic              long_enough;
    logic              fire;

    always_comb
    begin
        eq           = (level == settled_reg);
        pend_next    = pend_reg;
        cnt_next     = cnt_reg;
        settled_next = settled_reg;
        long_enough  = 1'b0;
        fire         = 1'b0;
        if (!pend_reg && !eq)
        begin
            pend_next = 1'b1;
            cnt_next  = '0;
        end
        else if (pend_reg && (cnt_reg != '1))
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        if (pend_next)
        begin
            long_enough = (cnt_next >= hold);
            fire        = long_enough;
            if (long_enough || eq)
            begin
                pend_next    = 1'b0;
                cnt_next     = '0;
                settled_next = level;
            end
        end
        enq = en && fire;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settled_reg <= 1'b0;
            pend_reg    <= 1'b0;
            cnt_reg     <= '0;
        end
        else if (en)
        begin
            settled_reg <= settled_next;
            pend_reg    <= pend_next;
            cnt_reg     <= cnt_next;
        end
    end

endmodule

// ===== sv/debounced_report_retransmit_queue.sv =====
// channel  dir  handshake          payload
// s        in   s_tvalid/s_tready  tuser: opcode; tdata: gate levels, ack code
// m        out  m_tvalid/m_tready  tdata: send fields, ack_matched, error, count
// cfg      in   cfg_we             cfg_index, cfg_data
//
// one request per cycle when it queues at most one message and the output buffer has room
// a tick that queues k > 1 messages holds s_tready low until the k - 1 extra
// messages are written from wbuf into the single-port message memory
// results pass through a two-entry output buffer, so otherwise s_tready drops
// only when both entries wait on m_tready
// async active-low reset; message memory needs no clearing pass
module debounced_report_retransmit_queue
    import drqr_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_W-1:0]      s_tdata,  // gate_a_level, gate_b_level, ack_code
    input  logic [0:0]           s_tuser,  // opcode
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // send_valid, send_code, send_gate, send_level, send_by_change,
    // send_is_retry, ack_matched, error_flag, queue_count
    output logic [((21 + $clog2(QUEUE_DEPTH + 1) + 7) / 8) * 8 - 1:0] m_tdata
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int RES_W = 21 + CNT_W;
    localparam int OUT_W = ((RES_W + 7) / 8) * 8;

    logic [HOLD_W-1:0]   hold_ms_reg;
    logic [WAIT_W-1:0]   resend_wait_reg;
    logic [RETRY_W-1:0]  retry_limit_reg;
    logic [PERIOD_W-1:0] report_period_reg;

    logic [PERIOD_W-1:0] report_cnt_reg, report_cnt_next;
    logic [WAIT_W-1:0]   wait_cnt_reg, wait_cnt_next;
    logic [RETRY_W-1:0]  retry_cnt_reg, retry_cnt_next;
    logic                send_pend_reg, send_pend_next;
    logic                err_reg, err_next;
    logic [IDX_W-1:0]    head_reg, head_next;
    logic [IDX_W-1:0]    tail_reg, tail_next;
    logic [CNT_W-1:0]    held_reg, held_next;

    msg_t                mem [QUEUE_DEPTH];
    msg_t                mem_q;
    logic                fwd_valid_reg;
    msg_t                fwd_data_reg;
    logic                we;
    logic [IDX_W-1:0]    wa;
    msg_t                wd;
    msg_t                head_entry;

    msg_t                wbuf_reg [MAX_DRAWS-1];
    msg_t                wbuf_next [MAX_DRAWS-1];
    logic [1:0]          wcnt_reg, wcnt_next;
    logic [IDX_W-1:0]    waddr_reg, waddr_next;

    logic [RES_W-1:0]    obuf_reg [2];
    logic [RES_W-1:0]    obuf_next [2];
    logic [1:0]          ocnt_reg, ocnt_next;

    logic                accept;
    logic                is_tick;
    logic                is_ack;
    logic                level_a;
    logic                level_b;
    code_t               ack_code;
    logic [PERIOD_W-1:0] report_inc;
    logic                rep_fire;
    logic                enq_a;
    logic                enq_b;
    logic [MAX_DRAWS-1:0] att;
    msg_t                cand [MAX_DRAWS];
    msg_t                list [MAX_DRAWS];
    code_t               codes [MAX_DRAWS];
    logic [2:0]          draws;
    logic [2:0]          n_st;
    logic [CNT_W-1:0]    held_q;
    logic [IDX_W-1:0]    tail_walk;
    logic [IDX_W-1:0]    first_addr;
    logic [WAIT_W-1:0]   wait_inc;
    logic                sv;
    logic                retry;
    logic                matched;
    msg_t                cur;
    msg_t                sent;
    logic [RES_W-1:0]    res;
    logic                pop;
    logic [CNT_W:0]      ring_sum;

    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
        idx_inc = (i == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    drqr_code_gen u_code_gen (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (cfg_we && (cfg_index == CFG_CODE_SEED)),
        .seed    (cfg_data[SEED_W-1:0]),
        .advance (is_tick),
        .steps   (draws),
        .codes   (codes)
    );

    drqr_debounce u_deb_a (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (is_tick),
        .level (level_a),
        .hold  (hold_ms_reg),
        .enq   (enq_a)
    );

    drqr_debounce u_deb_b (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (is_tick),
        .level (level_b),
        .hold  (hold_ms_reg),
        .enq   (enq_b)
    );

    assign s_tready   = (ocnt_reg != 2'd2) && (wcnt_reg == '0);
    assign accept     = s_tvalid && s_tready;
    assign is_tick    = accept && (op_t'(s_tuser[0]) == OP_TICK);
    assign is_ack     = accept && (op_t'(s_tuser[0]) == OP_ACK);
    assign level_a    = s_tdata[0];
    assign level_b    = s_tdata[1];
    assign ack_code   = s_tdata[IN_W-1:2];
    assign head_entry = fwd_valid_reg ? fwd_data_reg : mem_q;
    assign m_tvalid   = (ocnt_reg != '0);
    assign m_tdata    = OUT_W'(obuf_reg[0]);
    assign pop        = m_tvalid && m_tready;

    // tick: reports, debounce, enqueue and send; ack: match and dequeue the head
    always_comb
    begin
        report_inc = (report_cnt_reg != '1) ? report_cnt_reg + 1'b1 : report_cnt_reg;
        rep_fire   = is_tick && (report_inc >= report_period_reg);
        report_cnt_next = report_cnt_reg;
        if (is_tick)
        begin
            report_cnt_next = rep_fire ? '0 : report_inc;
        end

        att     = {enq_b, enq_a, rep_fire, rep_fire};
        cand[0] = '{by_change: 1'b0, level: level_a, gate: 1'b0, code: '0};
        cand[1] = '{by_change: 1'b0, level: level_b, gate: 1'b1, code: '0};
        cand[2] = '{by_change: 1'b1, level: level_a, gate: 1'b0, code: '0};
        cand[3] = '{by_change: 1'b1, level: level_b, gate: 1'b1, code: '0};
        draws   = '0;
        for (int k = 0; k < MAX_DRAWS; k++)
        begin
            if (att[k])
            begin
                cand[k].code = codes[draws[1:0]];
                draws        = draws + 1'b1;
            end
        end

        // a code is drawn even when a full queue drops the message
        held_q     = held_reg;
        n_st       = '0;
        tail_walk  = tail_reg;
        first_addr = tail_reg;
        for (int k = 0; k < MAX_DRAWS; k++)
        begin
            list[k] = '0;
        end
        for (int k = 0; k < MAX_DRAWS; k++)
        begin
            if (att[k] && (held_q < CNT_W'(QUEUE_DEPTH)))
            begin
                list[n_st[1:0]] = cand[k];
                n_st            = n_st + 1'b1;
                held_q          = held_q + 1'b1;
                tail_walk       = idx_inc(tail_walk);
            end
        end

        wait_inc       = (wait_cnt_reg != '1) ? wait_cnt_reg + 1'b1 : wait_cnt_reg;
        cur            = (held_reg != '0) ? head_entry : list[0];
        sv             = 1'b0;
        retry          = 1'b0;
        matched        = 1'b0;
        wait_cnt_next  = wait_cnt_reg;
        retry_cnt_next = retry_cnt_reg;
        send_pend_next = send_pend_reg;
        err_next       = err_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        held_next      = held_reg;

        if (is_tick)
        begin
            tail_next = tail_walk;
            held_next = held_q;
            if (held_q != '0)
            begin
                if (!send_pend_reg)
                begin
                    send_pend_next = 1'b1;
                    wait_cnt_next  = '0;
                    sv             = 1'b1;
                end
                else
                begin
                    wait_cnt_next = wait_inc;
                    if (wait_inc >= resend_wait_reg)
                    begin
                        if (retry_cnt_reg <= retry_limit_reg)
                        begin
                            if (retry_cnt_reg != '1)
                            begin
                                retry_cnt_next = retry_cnt_reg + 1'b1;
                            end
                            wait_cnt_next = '0;
                            sv            = 1'b1;
                            retry         = 1'b1;
                        end
                        else
                        begin
                            err_next = 1'b1;
                        end
                    end
                end
            end
        end
        else if (is_ack && (held_reg != '0) && (head_entry.code == ack_code))
        begin
            head_next      = idx_inc(head_reg);
            held_next      = held_reg - 1'b1;
            send_pend_next = 1'b0;
            retry_cnt_next = '0;
            wait_cnt_next  = '0;
            matched        = 1'b1;
        end

        sent = sv ? cur : '0;
        res  = {held_next, err_next, matched, retry,
                sent.by_change, sent.level, sent.gate, sent.code, sv};
    end

    // memory writes: first message at request time, the rest drained from wbuf
    always_comb
    begin
        we         = 1'b0;
        wa         = waddr_reg;
        wd         = wbuf_reg[0];
        wcnt_next  = wcnt_reg;
        waddr_next = waddr_reg;
        for (int j = 0; j < MAX_DRAWS - 1; j++)
        begin
            wbuf_next[j] = wbuf_reg[j];
        end
        if (wcnt_reg != '0)
        begin
            we         = 1'b1;
            wcnt_next  = wcnt_reg - 1'b1;
            waddr_next = idx_inc(waddr_reg);
            for (int j = 0; j < MAX_DRAWS - 2; j++)
            begin
                wbuf_next[j] = wbuf_reg[j+1];
            end
        end
        else if (is_tick && (n_st != '0))
        begin
            we         = 1'b1;
            wa         = first_addr;
            wd         = list[0];
            wcnt_next  = 2'(n_st - 1'b1);
            waddr_next = idx_inc(first_addr);
            for (int j = 0; j < MAX_DRAWS - 1; j++)
            begin
                wbuf_next[j] = list[j+1];
            end
        end
    end

    // two-entry output buffer
    always_comb
    begin
        ocnt_next    = ocnt_reg;
        obuf_next[0] = obuf_reg[0];
        obuf_next[1] = obuf_reg[1];
        priority if (accept && !pop)
        begin
            if (ocnt_reg == '0)
            begin
                obuf_next[0] = res;
            end
            else
            begin
                obuf_next[1] = res;
            end
            ocnt_next = ocnt_reg + 1'b1;
        end
        else if (pop && !accept)
        begin
            obuf_next[0] = obuf_reg[1];
            ocnt_next    = ocnt_reg - 1'b1;
        end
        else if (pop && accept)
        begin
            if (ocnt_reg == 2'd1)
            begin
                obuf_next[0] = res;
            end
            else
            begin
                obuf_next[0] = obuf_reg[1];
                obuf_next[1] = res;
            end
        end
        else
        begin
            ocnt_next = ocnt_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        mem_q <= mem[head_next];
    end

    always_ff @(posedge clk)
    begin
        fwd_data_reg <= wd;
        obuf_reg[0]  <= obuf_next[0];
        obuf_reg[1]  <= obuf_next[1];
        for (int j = 0; j < MAX_DRAWS - 1; j++)
        begin
            wbuf_reg[j] <= wbuf_next[j];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_ms_reg       <= HOLD_RESET;
            resend_wait_reg   <= TIMEOUT_RESET;
            retry_limit_reg   <= RETRIES_RESET;
            report_period_reg <= PERIOD_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_HOLD:          hold_ms_reg       <= cfg_data[HOLD_W-1:0];
                CFG_RESEND_WAIT:   resend_wait_reg   <= cfg_data[WAIT_W-1:0];
                CFG_RETRY_LIMIT:   retry_limit_reg   <= cfg_data[RETRY_W-1:0];
                CFG_REPORT_PERIOD: report_period_reg <= cfg_data[PERIOD_W-1:0];
                CFG_CODE_SEED:     ;
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            report_cnt_reg <= '0;
            wait_cnt_reg   <= '0;
            retry_cnt_reg  <= '0;
            send_pend_reg  <= 1'b0;
            err_reg        <= 1'b0;
            head_reg       <= '0;
            tail_reg       <= '0;
            held_reg       <= '0;
            wcnt_reg       <= '0;
            waddr_reg      <= '0;
            ocnt_reg       <= '0;
            fwd_valid_reg  <= 1'b0;
        end
        else
        begin
            report_cnt_reg <= report_cnt_next;
            wait_cnt_reg   <= wait_cnt_next;
            retry_cnt_reg  <= retry_cnt_next;
            send_pend_reg  <= send_pend_next;
            err_reg        <= err_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            held_reg       <= held_next;
            wcnt_reg       <= wcnt_next;
            waddr_reg      <= waddr_next;
            ocnt_reg       <= ocnt_next;
            fwd_valid_reg  <= we && (wa == head_next);
        end
    end

    assign ring_sum = {1'b0, held_reg} + (CNT_W + 1)'(head_reg);

    a_drain_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (wcnt_reg != '0) |-> !s_tready)
        else $error("request taken while queued writes drain");

    a_held_max: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("held count above depth");

    a_ring: assert property (@(posedge clk) disable iff (!rst_n)
        (ring_sum >= (CNT_W + 1)'(QUEUE_DEPTH))
            ? ((CNT_W + 1)'(tail_reg) == ring_sum - (CNT_W + 1)'(QUEUE_DEPTH))
            : ((CNT_W + 1)'(tail_reg) == ring_sum))
        else $error("head, tail and held count disagree");

    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg |=> err_reg)
        else $error("error flag cleared");

    a_ack_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        is_ack |-> !we)
        else $error("memory write during ack");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import drqr_pkg::*;

    localparam int DEPTH = 16;
    localparam int COUNT_W = $clog2(DEPTH + 1);
    localparam int OUT_W = ((21 + COUNT_W + 7) / 8) * 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_STALL_AT = 300;
    localparam int LONG_STALL_CYCLES = 150;

    typedef enum logic [1:0] {
        REQ_TICK,
        REQ_ACK,
        REQ_ACK_HEAD
    } req_kind_t;

    typedef struct {
        req_kind_t kind;
        logic      lvl_a;
        logic      lvl_b;
        code_t     code;
    } gate_req_t;

    // one result, lowest field last
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               error;
        logic               matched;
        logic               retry;
        logic               by_change;
        logic               level;
        logic               gate;
        code_t              code;
        logic               valid;
    } report_t;

    localparam int REPORT_W = $bits(report_t);

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [IN_W-1:0]      s_tdata = '0;   // gate_a_level, gate_b_level, ack_code
    logic [0:0]           s_tuser = '0;   // opcode
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // send_valid, send_code, send_gate, send_level, send_by_change,
    // send_is_retry, ack_matched, error_flag, queue_count
    logic [OUT_W-1:0]     m_tdata;

    debounced_report_retransmit_queue #(.QUEUE_DEPTH(DEPTH)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #10 clk = ~clk;

    // predicted state of the reporter
    logic [HOLD_W-1:0]   hold_ms = HOLD_RESET;
    logic [WAIT_W-1:0]   resend_wait = TIMEOUT_RESET;
    logic [RETRY_W-1:0]  retry_limit = RETRIES_RESET;
    logic [PERIOD_W-1:0] report_period = PERIOD_RESET;
    logic [LFSR_W-1:0]   code_lfsr = SEED_RESET;
    logic                settled [2] = '{1'b0, 1'b0};
    logic                hold_pending [2] = '{1'b0, 1'b0};
    logic [HOLD_W-1:0]   hold_cnt [2] = '{'0, '0};
    logic [PERIOD_W-1:0] report_cnt = '0;
    logic [WAIT_W-1:0]   wait_cnt = '0;
    logic [RETRY_W-1:0]  retry_cnt = '0;
    logic                send_pending = 1'b0;
    logic                error_latch = 1'b0;
    msg_t                msg_store [DEPTH];
    int                  head_ptr = 0;
    int                  tail_ptr = 0;
    int                  held_msgs = 0;

    gate_req_t pending_requests [$];
    report_t   expected_reports [$];

    bit          idle_on = 1'b1;
    bit          offer_live = 1'b0;
    op_t         offer_op = OP_TICK;
    logic        offer_a = 1'b0;
    logic        offer_b = 1'b0;
    code_t       offer_code = '0;
    int          send_gap = 0;
    int          send_calm = 0;
    int          sink_gap = 0;
    int          sink_calm = 0;
    int          sink_hold = 0;
    int          results_seen = 0;
    int unsigned fail_count = 0;
    int          cycle_count = 0;

    function automatic code_t draw_code();
        int unsigned v;
        logic        lsb;
        lsb = code_lfsr[0];
        code_lfsr = code_lfsr >> 1;
        if (lsb)
            code_lfsr = code_lfsr ^ LFSR_TAPS;
        v = code_lfsr;
        return code_t'(v % CODE_MOD + 1);
    endfunction

    function automatic void queue_message(logic gate, logic level, logic by_change);
        code_t c;
        c = draw_code();
        if (held_msgs >= DEPTH)
            return;
        msg_store[tail_ptr] = '{by_change: by_change, level: level, gate: gate, code: c};
        tail_ptr = (tail_ptr + 1) % DEPTH;
        held_msgs++;
    endfunction

    function automatic void settle_gate(logic gate, logic level);
        logic same;
        logic long_enough;
        same = (level == settled[gate]);
        if (!hold_pending[gate] && !same)
        begin
            hold_pending[gate] = 1'b1;
            hold_cnt[gate] = '0;
        end
        else if (hold_pending[gate] && hold_cnt[gate] != '1)
        begin
            hold_cnt[gate]++;
        end
        if (!hold_pending[gate])
            return;
        long_enough = (hold_cnt[gate] >= hold_ms);
        if (long_enough)
            queue_message(gate, level, 1'b1);
        if (long_enough || same)
        begin
            hold_pending[gate] = 1'b0;
            hold_cnt[gate] = '0;
            settled[gate] = level;
        end
    endfunction

    function automatic report_t advance_reporter(op_t op, logic lvl_a, logic lvl_b, code_t ack);
        report_t r;
        msg_t    head_msg;
        logic    transmit;
        r = '0;
        transmit = 1'b0;
        head_msg = '0;
        if (op == OP_TICK)
        begin
            if (report_cnt != '1)
                report_cnt++;
            if (report_cnt >= report_period)
            begin
                report_cnt = '0;
                queue_message(1'b0, lvl_a, 1'b0);
                queue_message(1'b1, lvl_b, 1'b0);
            end
            settle_gate(1'b0, lvl_a);
            settle_gate(1'b1, lvl_b);
            if (held_msgs > 0)
            begin
                head_msg = msg_store[head_ptr];
                if (!send_pending)
                begin
                    send_pending = 1'b1;
                    wait_cnt = '0;
                    transmit = 1'b1;
                end
                else
                begin
                    if (wait_cnt != '1)
                        wait_cnt++;
                    if (wait_cnt >= resend_wait)
                    begin
                        if (retry_cnt <= retry_limit)
                        begin
                            if (retry_cnt != '1)
                                retry_cnt++;
                            wait_cnt = '0;
                            transmit = 1'b1;
                            r.retry = 1'b1;
                        end
                        else
                        begin
                            error_latch = 1'b1;
                        end
                    end
                end
            end
        end
        else if (held_msgs > 0 && msg_store[head_ptr].code == ack)
        begin
            head_ptr = (head_ptr + 1) % DEPTH;
            held_msgs--;
            send_pending = 1'b0;
            retry_cnt = '0;
            wait_cnt = '0;
            r.matched = 1'b1;
        end
        if (transmit)
        begin
            r.valid = 1'b1;
            r.code = head_msg.code;
            r.gate = head_msg.gate;
            r.level = head_msg.level;
            r.by_change = head_msg.by_change;
        end
        r.error = error_latch;
        r.count = COUNT_W'(held_msgs);
        return r;
    endfunction

    function automatic void apply_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        case (idx)
            CFG_HOLD:          hold_ms = data[HOLD_W-1:0];
            CFG_RESEND_WAIT:   resend_wait = data[WAIT_W-1:0];
            CFG_RETRY_LIMIT:   retry_limit = data[RETRY_W-1:0];
            CFG_REPORT_PERIOD: report_period = data[PERIOD_W-1:0];
            CFG_CODE_SEED:
            begin
                code_lfsr = data[SEED_W-1:0];
                if (code_lfsr == '0)
                    code_lfsr = 1;
            end
            default: ;
        endcase
    endfunction

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    // request driver
    always @(posedge clk)
    begin : request_driver
        gate_req_t req;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                expected_reports.push_back(
                    advance_reporter(offer_op, offer_a, offer_b, offer_code));
                offer_live = 1'b0;
                if (idle_on && send_calm == 0 && $urandom_range(0, 3) == 0)
                    send_gap = $urandom_range(1, 9);
            end
            if (send_calm > 0)
                send_calm--;
            else if ($urandom_range(0, 59) == 0)
                send_calm = $urandom_range(20, 80);
            if (!offer_live)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                end
                else if (pending_requests.size() > 0)
                begin
                    req = pending_requests.pop_front();
                    offer_op = (req.kind == REQ_TICK) ? OP_TICK : OP_ACK;
                    offer_a = req.lvl_a;
                    offer_b = req.lvl_b;
                    offer_code = req.code;
                    if (req.kind == REQ_ACK_HEAD && held_msgs > 0)
                        offer_code = msg_store[head_ptr].code;
                    s_tdata <= {offer_code, offer_b, offer_a};
                    s_tuser <= offer_op;
                    offer_live = 1'b1;
                end
            end
            s_tvalid <= offer_live;
        end
    end

    // result monitor
    always @(posedge clk)
    begin : result_monitor
        report_t got;
        report_t want;
        logic    ready_next;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = report_t'(m_tdata[REPORT_W-1:0]);
                results_seen++;
                if (expected_reports.size() == 0)
                begin
                    $display("%0t: result with nothing expected, actual %h", $time, m_tdata);
                    fail_count++;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    check_field("send_valid", want.valid, got.valid);
                    check_field("send_code", want.code, got.code);
                    check_field("send_gate", want.gate, got.gate);
                    check_field("send_level", want.level, got.level);
                    check_field("send_by_change", want.by_change, got.by_change);
                    check_field("send_is_retry", want.retry, got.retry);
                    check_field("ack_matched", want.matched, got.matched);
                    check_field("error_flag", want.error, got.error);
                    check_field("queue_count", want.count, got.count);
                    check_field("padding", 0, m_tdata >> REPORT_W);
                end
                if (results_seen == LONG_STALL_AT)
                    sink_hold = LONG_STALL_CYCLES;
            end
            if (sink_hold > 0)
            begin
                sink_hold--;
                ready_next = 1'b0;
            end
            else
            begin
                if (sink_calm > 0)
                    sink_calm--;
                else if ($urandom_range(0, 59) == 0)
                    sink_calm = $urandom_range(20, 80);
                if (sink_gap > 0)
                begin
                    sink_gap--;
                    ready_next = 1'b0;
                end
                else if (idle_on && sink_calm == 0 && $urandom_range(0, 4) == 0)
                begin
                    sink_gap = $urandom_range(1, 9) - 1;
                    ready_next = 1'b0;
                end
                else
                begin
                    ready_next = 1'b1;
                end
            end
            m_tready <= ready_next;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic push_tick(logic a, logic b);
        pending_requests.push_back('{REQ_TICK, a, b, code_t'($urandom)});
    endtask

    task automatic push_ack(req_kind_t kind, code_t code);
        pending_requests.push_back('{kind, 1'($urandom), 1'($urandom), code});
    endtask

    task automatic wait_idle();
        while (pending_requests.size() != 0 || offer_live || expected_reports.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        apply_config(idx, data);
    endtask

    task automatic finish_writes();
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_timing(int hold, int timeout, int retries, int period);
        write_reg(CFG_HOLD, CFG_W'(hold));
        write_reg(CFG_RESEND_WAIT, CFG_W'(timeout));
        write_reg(CFG_RETRY_LIMIT, CFG_W'(retries));
        write_reg(CFG_REPORT_PERIOD, CFG_W'(period));
        write_reg(CFG_CODE_SEED, CFG_W'($urandom_range(1, 65535)));
        finish_writes();
    endtask

    // ticks with slowly changing levels plus glitches, mixed with acks
    task automatic run_traffic(int count, int ack_pct, int head_pct, int flip_pct);
        logic lvl_a;
        logic lvl_b;
        lvl_a = 1'($urandom);
        lvl_b = 1'($urandom);
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 99) < ack_pct)
            begin
                if ($urandom_range(0, 99) < head_pct)
                    push_ack(REQ_ACK_HEAD, code_t'($urandom));
                else
                    push_ack(REQ_ACK, code_t'($urandom));
            end
            else
            begin
                if ($urandom_range(0, 99) < flip_pct)
                    lvl_a = ~lvl_a;
                if ($urandom_range(0, 99) < flip_pct)
                    lvl_b = ~lvl_b;
                if ($urandom_range(0, 19) == 0)
                    push_tick(~lvl_a, lvl_b);
                else if ($urandom_range(0, 19) == 0)
                    push_tick(lvl_a, ~lvl_b);
                else
                    push_tick(lvl_a, lvl_b);
            end
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: long hold, nothing gets queued
        push_tick(1'b0, 1'b0);
        push_tick(1'b1, 1'b1);
        push_tick(1'b1, 1'b1);
        push_tick(1'b0, 1'b1);
        push_tick(1'b1, 1'b0);
        push_tick(1'b0, 1'b0);
        push_ack(REQ_ACK, '0);
        push_ack(REQ_ACK, '1);
        push_ack(REQ_ACK_HEAD, code_t'(CODE_MOD));
        wait_idle();

        // zero hold, timeout and period, zero seed, upper data bits dropped
        write_reg(CFG_HOLD, 24'hFF0000);
        write_reg(CFG_RESEND_WAIT, 24'hAB0000);
        write_reg(CFG_RETRY_LIMIT, 24'hFFFF3F);
        write_reg(CFG_REPORT_PERIOD, '0);
        write_reg(CFG_CODE_SEED, 24'h5A0000);
        for (int i = int'(CFG_CODE_SEED) + 1; i < (1 << CFG_IDX_W); i++)
            write_reg(CFG_IDX_W'(i), CFG_W'($urandom));
        finish_writes();
        push_tick(1'b1, 1'b1);
        push_tick(1'b0, 1'b0);
        push_tick(1'b1, 1'b0);
        push_tick(1'b0, 1'b1);
        push_tick(1'b1, 1'b1);
        push_ack(REQ_ACK_HEAD, '0);
        push_ack(REQ_ACK_HEAD, '0);
        push_ack(REQ_ACK, '0);
        push_ack(REQ_ACK, '1);
        push_tick(1'b1, 1'b1);
        push_ack(REQ_ACK_HEAD, '0);
        push_tick(1'b0, 1'b0);
        push_ack(REQ_ACK_HEAD, '0);
        wait_idle();

        set_timing($urandom_range(1, 4), $urandom_range(4, 12), 3, $urandom_range(25, 60));
        run_traffic(500, 25, 75, 15);
        wait_idle();

        // queue stays full, drops
        set_timing(1, 1, 5, 3);
        run_traffic(300, 15, 80, 30);
        wait_idle();

        // upper extremes
        write_reg(CFG_HOLD, 24'd65535);
        write_reg(CFG_RESEND_WAIT, 24'd65535);
        write_reg(CFG_RETRY_LIMIT, 24'd63);
        write_reg(CFG_REPORT_PERIOD, 24'hFFFFFF);
        write_reg(CFG_CODE_SEED, 24'd65535);
        finish_writes();
        run_traffic(150, 20, 90, 10);
        wait_idle();

        // no acks for a while: retry count saturates, resends go on
        set_timing(3, 1, 63, 40);
        run_traffic(200, 0, 0, 10);
        run_traffic(250, 30, 80, 10);
        wait_idle();

        // retry limit of zero: one resend per message, then the error flag
        idle_on = 1'b0;
        set_timing(2, 2, 0, 30);
        run_traffic(350, 10, 50, 15);
        wait_idle();
        repeat (20) @(posedge clk);

        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
sv/drqr_pkg.sv
sv/drqr_code_gen.sv
sv/drqr_debounce.sv
sv/debounced_report_retransmit_queue.sv
bench/testbench.sv
